/* rtl/plcil_pkg.sv */
package plcil_pkg;

    localparam int WORD_BITS   = 16;
    localparam int STACK_DEPTH = 8;

    // Stack level counts 0 .. STACK_DEPTH, a stack index only 0 .. STACK_DEPTH-1.
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    // Step counter of the iterative multiply and divide unit.
    localparam int CNT_W = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;

    localparam logic [4:0] CMD_LD   = 5'd0;
    localparam logic [4:0] CMD_ST   = 5'd1;
    localparam logic [4:0] CMD_LDN  = 5'd2;
    localparam logic [4:0] CMD_STN  = 5'd3;
    localparam logic [4:0] CMD_S    = 5'd4;
    localparam logic [4:0] CMD_R    = 5'd5;
    localparam logic [4:0] CMD_CAL  = 5'd6;
    localparam logic [4:0] CMD_RET  = 5'd7;
    localparam logic [4:0] CMD_JMP  = 5'd8;
    localparam logic [4:0] CMD_END  = 5'd9;
    localparam logic [4:0] CMD_AND  = 5'd10;
    localparam logic [4:0] CMD_OR   = 5'd11;
    localparam logic [4:0] CMD_XOR  = 5'd12;
    localparam logic [4:0] CMD_ANDN = 5'd13;
    localparam logic [4:0] CMD_ORN  = 5'd14;
    localparam logic [4:0] CMD_XORN = 5'd15;
    localparam logic [4:0] CMD_ADD  = 5'd16;
    localparam logic [4:0] CMD_SUB  = 5'd17;
    localparam logic [4:0] CMD_MUL  = 5'd18;
    localparam logic [4:0] CMD_DIV  = 5'd19;
    localparam logic [4:0] CMD_GT   = 5'd20;
    localparam logic [4:0] CMD_GE   = 5'd21;
    localparam logic [4:0] CMD_EQ   = 5'd22;
    localparam logic [4:0] CMD_NE   = 5'd23;
    localparam logic [4:0] CMD_LE   = 5'd24;
    localparam logic [4:0] CMD_LT   = 5'd25;
    localparam logic [4:0] CMD_POP  = 5'd26;

    localparam logic [1:0] MOD_PUSH = 2'd1;
    localparam logic [1:0] MOD_NEG  = 2'd2;

    localparam logic [2:0] FAULT_OK      = 3'd0;
    localparam logic [2:0] FAULT_ILLEGAL = 3'd1;
    localparam logic [2:0] FAULT_OVER    = 3'd2;
    localparam logic [2:0] FAULT_UNDER   = 3'd3;
    localparam logic [2:0] FAULT_DIVZERO = 3'd4;

    typedef struct packed {
        logic  start;
        logic  div;
        t_word a;
        t_word b;
    } t_md_req;

    typedef struct packed {
        logic  done;
        t_word result;
    } t_md_rsp;

endpackage

/* rtl/plc_instruction_list_executor_unit.sv */
// Instruction-list accumulator unit for a PLC scan engine.
// The input channel (i_valid / o_stall) carries one instruction per item: the
// opcode, its modifier, the operand word already read from memory and the
// operand address. The output channel (o_valid / i_stall) returns one item per
// instruction: the accumulator after the instruction, a store request (valid
// flag, address and value), the end-of-scan flag and a fault code.
// An item is accepted at a clock edge with valid high and stall low.
// The unit takes an item only when its sequencer is idle. Most instructions
// show their result when the sequencer returns to idle, and the unit is ready
// for the next item at that same point, so it never takes a new item before
// the last one is finished. MUL, and DIV with a nonzero divisor, run through
// the shared multiply/divide unit, one bit per cycle, before the result shows.
// The result sits in an output register. When the receiver stalls, the
// sequencer still takes and executes the next item and holds it until the
// output register is free, so at most one finished item waits inside.
// Synchronous reset (i_rst_n low) clears the accumulator, the stack level,
// the sequencer and the output valid. Stack entries are not cleared; only
// entries below the current level are ever read.
module plc_instruction_list_executor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_cmd,
    input  logic [1:0]  i_modifier,
    input  logic [15:0] i_operand_value,
    input  logic [7:0]  i_area,
    input  logic [7:0]  i_byte_index,
    input  logic [2:0]  i_bit_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_accumulator,
    output logic        o_store_valid,
    output logic [7:0]  o_store_area,
    output logic [7:0]  o_store_byte,
    output logic [2:0]  o_store_bit,
    output logic [15:0] o_store_value,
    output logic        o_scan_end,
    output logic [2:0]  o_fault
);

    // Sequencer: IDLE waits for an item, EXEC runs the instruction directly or
    // starts the multiply/divide unit, WAIT waits for that unit, and
    // DONE moves the result into the output register once it is free.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Captured instruction.
    logic [4:0]       r_cmd;
    logic [1:0]       r_mod;
    plcil_pkg::t_word r_opv;
    logic [7:0]       r_area;
    logic [7:0]       r_byte;
    logic [2:0]       r_bit;

    // Architectural state.
    plcil_pkg::t_word            r_acc;
    plcil_pkg::t_word            n_acc;
    logic [plcil_pkg::LVL_W-1:0] r_lvl;
    logic [plcil_pkg::LVL_W-1:0] n_lvl;
    plcil_pkg::t_word            r_valstk [plcil_pkg::STACK_DEPTH];
    logic [4:0]                  r_opstk  [plcil_pkg::STACK_DEPTH];
    logic                        push_we;

    // Per-instruction result side information.
    logic             r_st;
    logic             n_st;
    plcil_pkg::t_word r_sval;
    plcil_pkg::t_word n_sval;
    logic             r_end;
    logic             n_end;
    logic [2:0]       r_fault;
    logic [2:0]       n_fault;

    // Output register.
    logic             r_out_valid;
    logic             n_out_valid;
    logic             load_out;
    plcil_pkg::t_word r_o_acc;
    logic             r_o_st;
    logic [7:0]       r_o_area;
    logic [7:0]       r_o_byte;
    logic [2:0]       r_o_bit;
    plcil_pkg::t_word r_o_sval;
    logic             r_o_end;
    logic [2:0]       r_o_fault;

    // Operand selection and combinational ALU.
    logic                        is_pop;
    logic [plcil_pkg::LVL_W-1:0] lvl_m1;
    logic [plcil_pkg::IDX_W-1:0] pop_idx;
    logic [plcil_pkg::IDX_W-1:0] push_idx;
    logic [4:0]                  alu_op;
    plcil_pkg::t_word            alu_a;
    plcil_pkg::t_word            alu_b;
    plcil_pkg::t_word            alu_res;
    logic [2:0]                  alu_fault;
    logic                        alu_md;

    plcil_pkg::t_md_req md_req;
    plcil_pkg::t_md_rsp md_rsp;

    plcil_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign o_stall = (r_state != ST_IDLE);

    // A pop combines the saved value (left side) with the accumulator using
    // the saved operator; any other ALU op combines the accumulator with the
    // operand, complemented under the negate modifier.
    always_comb begin
        is_pop   = (r_cmd == plcil_pkg::CMD_POP);
        lvl_m1   = r_lvl - plcil_pkg::LVL_W'(1);
        pop_idx  = lvl_m1[plcil_pkg::IDX_W-1:0];
        push_idx = r_lvl[plcil_pkg::IDX_W-1:0];
        alu_op   = is_pop ? r_opstk[pop_idx] : r_cmd;
        alu_a    = is_pop ? r_valstk[pop_idx] : r_acc;
        if (is_pop) begin
            alu_b = r_acc;
        end else if (r_mod == plcil_pkg::MOD_NEG) begin
            alu_b = ~r_opv;
        end else begin
            alu_b = r_opv;
        end

        alu_res   = alu_a;
        alu_fault = plcil_pkg::FAULT_OK;
        alu_md    = 1'b0;
        case (alu_op)
            plcil_pkg::CMD_AND:  alu_res = alu_a & alu_b;
            plcil_pkg::CMD_OR:   alu_res = alu_a | alu_b;
            plcil_pkg::CMD_XOR:  alu_res = alu_a ^ alu_b;
            plcil_pkg::CMD_ANDN: alu_res = alu_a & ~alu_b;
            plcil_pkg::CMD_ORN:  alu_res = alu_a | ~alu_b;
            plcil_pkg::CMD_XORN: alu_res = alu_a ^ ~alu_b;
            plcil_pkg::CMD_ADD:  alu_res = alu_a + alu_b;
            plcil_pkg::CMD_SUB:  alu_res = alu_a - alu_b;
            plcil_pkg::CMD_MUL:  alu_md  = 1'b1;
            plcil_pkg::CMD_DIV: begin
                if (alu_b == '0) begin
                    alu_res   = '1;
                    alu_fault = plcil_pkg::FAULT_DIVZERO;
                end else begin
                    alu_md = 1'b1;
                end
            end
            plcil_pkg::CMD_GT:   alu_res = plcil_pkg::t_word'(alu_a >  alu_b);
            plcil_pkg::CMD_GE:   alu_res = plcil_pkg::t_word'(alu_a >= alu_b);
            plcil_pkg::CMD_EQ:   alu_res = plcil_pkg::t_word'(alu_a == alu_b);
            plcil_pkg::CMD_NE:   alu_res = plcil_pkg::t_word'(alu_a != alu_b);
            plcil_pkg::CMD_LE:   alu_res = plcil_pkg::t_word'(alu_a <= alu_b);
            plcil_pkg::CMD_LT:   alu_res = plcil_pkg::t_word'(alu_a <  alu_b);
            default:             alu_fault = plcil_pkg::FAULT_ILLEGAL;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_lvl        = r_lvl;
        n_st         = r_st;
        n_sval       = r_sval;
        n_end        = r_end;
        n_fault      = r_fault;
        push_we      = 1'b0;
        load_out     = 1'b0;
        n_out_valid  = r_out_valid && i_stall;
        md_req.start = 1'b0;
        md_req.div   = (alu_op == plcil_pkg::CMD_DIV);
        md_req.a     = alu_a;
        md_req.b     = alu_b;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                n_st    = 1'b0;
                n_sval  = '0;
                n_end   = 1'b0;
                n_fault = plcil_pkg::FAULT_OK;
                case (r_cmd)
                    plcil_pkg::CMD_LD:  n_acc = r_opv;
                    plcil_pkg::CMD_LDN: n_acc = ~r_opv;
                    plcil_pkg::CMD_ST: begin
                        n_st   = 1'b1;
                        n_sval = r_acc;
                    end
                    plcil_pkg::CMD_STN: begin
                        n_st   = 1'b1;
                        n_sval = ~r_acc;
                    end
                    plcil_pkg::CMD_S, plcil_pkg::CMD_R: begin
                        // Set and reset act only on an accumulator equal to one.
                        if (r_acc == plcil_pkg::t_word'(1)) begin
                            n_st   = 1'b1;
                            n_sval = plcil_pkg::t_word'(r_cmd == plcil_pkg::CMD_S);
                        end
                    end
                    plcil_pkg::CMD_CAL, plcil_pkg::CMD_RET, plcil_pkg::CMD_JMP: begin
                        n_acc = r_acc;
                    end
                    plcil_pkg::CMD_END: begin
                        n_end = 1'b1;
                        n_acc = '0;
                        n_lvl = '0;
                    end
                    plcil_pkg::CMD_POP: begin
                        if (r_lvl == '0) begin
                            n_fault = plcil_pkg::FAULT_UNDER;
                        end else begin
                            n_lvl   = lvl_m1;
                            n_fault = alu_fault;
                            if (alu_md) begin
                                md_req.start = 1'b1;
                                n_state      = ST_WAIT;
                            end else begin
                                n_acc = alu_res;
                            end
                        end
                    end
                    default: begin
                        if ((r_cmd >= plcil_pkg::CMD_AND) && (r_cmd <= plcil_pkg::CMD_LT)) begin
                            if (r_mod == plcil_pkg::MOD_PUSH) begin
                                // Open parenthesis: save acc and operator, load operand.
                                if (r_lvl >= plcil_pkg::LVL_W'(plcil_pkg::STACK_DEPTH)) begin
                                    n_fault = plcil_pkg::FAULT_OVER;
                                end else begin
                                    push_we = 1'b1;
                                    n_lvl   = r_lvl + plcil_pkg::LVL_W'(1);
                                    n_acc   = r_opv;
                                end
                            end else begin
                                n_fault = alu_fault;
                                if (alu_md) begin
                                    md_req.start = 1'b1;
                                    n_state      = ST_WAIT;
                                end else begin
                                    n_acc = alu_res;
                                end
                            end
                        end else begin
                            n_fault = plcil_pkg::FAULT_ILLEGAL;
                        end
                    end
                endcase
            end
            ST_WAIT: begin
                if (md_rsp.done) begin
                    n_acc   = md_rsp.result;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_valid) begin
            r_cmd  <= i_cmd;
            r_mod  <= i_modifier;
            r_opv  <= i_operand_value;
            r_area <= i_area;
            r_byte <= i_byte_index;
            r_bit  <= i_bit_index;
        end
        if (push_we) begin
            r_valstk[push_idx] <= r_acc;
            r_opstk[push_idx]  <= r_cmd;
        end
        r_st    <= n_st;
        r_sval  <= n_sval;
        r_end   <= n_end;
        r_fault <= n_fault;
        if (load_out) begin
            r_o_acc   <= r_acc;
            r_o_st    <= r_st;
            r_o_area  <= r_st ? r_area : '0;
            r_o_byte  <= r_st ? r_byte : '0;
            r_o_bit   <= r_st ? r_bit : '0;
            r_o_sval  <= r_st ? r_sval : '0;
            r_o_end   <= r_end;
            r_o_fault <= r_fault;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_accumulator = r_o_acc;
    assign o_store_valid = r_o_st;
    assign o_store_area  = r_o_area;
    assign o_store_byte  = r_o_byte;
    assign o_store_bit   = r_o_bit;
    assign o_store_value = r_o_sval;
    assign o_scan_end    = r_o_end;
    assign o_fault       = r_o_fault;

endmodule

/* rtl/plcil_muldiv.sv */
// Iterative unsigned multiply (shift and add, low word kept) and restoring
// divide. One bit per cycle, WORD_BITS steps per operation.
module plcil_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plcil_pkg::t_md_req i_req,
    output plcil_pkg::t_md_rsp o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_div;
    logic [plcil_pkg::CNT_W-1:0] r_cnt;
    plcil_pkg::t_word           r_x;
    plcil_pkg::t_word           r_y;
    plcil_pkg::t_word           r_p;

    logic [plcil_pkg::WORD_BITS:0] rem_sh;
    logic [plcil_pkg::WORD_BITS:0] rem_diff;
    plcil_pkg::t_word              prod_sum;

    always_comb begin
        rem_sh   = {r_p, r_x[plcil_pkg::WORD_BITS-1]};
        rem_diff = rem_sh - {1'b0, r_y};
        prod_sum = r_p + r_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.div;
            r_cnt <= plcil_pkg::CNT_W'(plcil_pkg::WORD_BITS - 1);
            r_x   <= i_req.a;
            r_y   <= i_req.b;
            r_p   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - plcil_pkg::CNT_W'(1);
            if (r_div) begin
                // The quotient bits shift into r_x as the dividend shifts out.
                if (!rem_diff[plcil_pkg::WORD_BITS]) begin
                    r_p <= rem_diff[plcil_pkg::WORD_BITS-1:0];
                    r_x <= {r_x[plcil_pkg::WORD_BITS-2:0], 1'b1};
                end else begin
                    r_p <= rem_sh[plcil_pkg::WORD_BITS-1:0];
                    r_x <= {r_x[plcil_pkg::WORD_BITS-2:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    r_p <= prod_sum;
                end
                r_x <= {r_x[plcil_pkg::WORD_BITS-2:0], 1'b0};
                r_y <= {1'b0, r_y[plcil_pkg::WORD_BITS-1:1]};
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_div ? r_x : r_p;

endmodule

/* test/tb_plc_instruction_list_executor_unit.sv */
module tb_plc_instruction_list_executor_unit;

    import plcil_pkg::*;

    // Modifier codes that the package does not name.
    localparam logic [1:0] MOD_NONE = 2'd0;
    localparam logic [1:0] MOD_RSVD = 2'd3;

    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 700;
    // Instructions issued per traffic phase (slow receiver / slow sender / no gaps).
    localparam int PHASE_LEN    = 250;
    // Longest instruction is MUL/DIV; the drain wait allows about twice its run.
    localparam int DRAIN_CYCLES = 2 * (WORD_BITS + 3);
    localparam int TIMEOUT      = 2_000_000;

    // One instruction as it is offered on the input channel. The hold flag makes
    // the driver wait until every earlier instruction has produced its result.
    typedef struct packed {
        logic [4:0] cmd;
        logic [1:0] modifier;
        t_word      operand;
        logic [7:0] area;
        logic [7:0] byte_index;
        logic [2:0] bit_index;
        logic       hold;
    } t_instr;

    // One result item of the output channel.
    typedef struct packed {
        t_word      acc;
        logic       store_valid;
        logic [7:0] store_area;
        logic [7:0] store_byte;
        logic [2:0] store_bit;
        t_word      store_value;
        logic       scan_end;
        logic [2:0] fault;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [4:0]  i_cmd = '0;
    logic [1:0]  i_modifier = '0;
    logic [15:0] i_operand_value = '0;
    logic [7:0]  i_area = '0;
    logic [7:0]  i_byte_index = '0;
    logic [2:0]  i_bit_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_accumulator;
    logic        o_store_valid;
    logic [7:0]  o_store_area;
    logic [7:0]  o_store_byte;
    logic [2:0]  o_store_bit;
    logic [15:0] o_store_value;
    logic        o_scan_end;
    logic [2:0]  o_fault;

    plc_instruction_list_executor_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_modifier      (i_modifier),
        .i_operand_value (i_operand_value),
        .i_area          (i_area),
        .i_byte_index    (i_byte_index),
        .i_bit_index     (i_bit_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_accumulator   (o_accumulator),
        .o_store_valid   (o_store_valid),
        .o_store_area    (o_store_area),
        .o_store_byte    (o_store_byte),
        .o_store_bit     (o_store_bit),
        .o_store_value   (o_store_value),
        .o_scan_end      (o_scan_end),
        .o_fault         (o_fault)
    );

    always #1 i_clk = ~i_clk;

    // Program still to be offered, and results predicted but not yet seen.
    t_instr  program_queue[$];
    t_result exec_results[$];

    int unsigned issued_count  = 0;
    int unsigned retired_count = 0;
    int unsigned error_count   = 0;
    logic [1:0]  phase = 2'd0;

    // Shadow copy of the unit's architectural state.
    t_word       acc_q = '0;
    t_word       value_stk [STACK_DEPTH];
    logic [4:0]  oper_stk  [STACK_DEPTH];
    int unsigned stk_level = 0;
    int unsigned max_level = 0;

    // Tallies for the closing summary.
    int unsigned store_tally = 0;
    int unsigned end_tally   = 0;
    int unsigned fault_tally [8];

    // Generator-side bookkeeping. Stack level effects are fully determined by
    // the instruction order, so the generator can track the depth exactly.
    int unsigned gen_level    = 0;
    int unsigned gen_effective = 0;
    logic        hold_req     = 1'b0;

    // The operator part of the instruction set. Operators other than the
    // sixteen ALU codes are reported as illegal, with the first operand kept.
    function automatic t_word alu_op(logic [4:0] op, t_word a, t_word b,
                                     output logic [2:0] fault);
        fault = FAULT_OK;
        case (op)
            CMD_AND:  return a & b;
            CMD_OR:   return a | b;
            CMD_XOR:  return a ^ b;
            CMD_ANDN: return a & ~b;
            CMD_ORN:  return a | ~b;
            CMD_XORN: return a ^ ~b;
            CMD_ADD:  return a + b;
            CMD_SUB:  return a - b;
            CMD_MUL:  return a * b;
            CMD_DIV: begin
                if (b == '0) begin
                    fault = FAULT_DIVZERO;
                    return '1;
                end
                return a / b;
            end
            CMD_GT:   return t_word'(a > b);
            CMD_GE:   return t_word'(a >= b);
            CMD_EQ:   return t_word'(a == b);
            CMD_NE:   return t_word'(a != b);
            CMD_LE:   return t_word'(a <= b);
            CMD_LT:   return t_word'(a < b);
            default: begin
                fault = FAULT_ILLEGAL;
                return a;
            end
        endcase
    endfunction

    // Executes one instruction against the shadow state and returns the
    // result item that the unit must produce for it.
    function automatic t_result execute_instr(t_instr ins);
        t_result    r;
        t_word      sval;
        t_word      b;
        logic [2:0] fault;
        r = '0;
        sval = '0;
        fault = FAULT_OK;
        if (ins.cmd == CMD_LD) begin
            acc_q = ins.operand;
        end else if (ins.cmd == CMD_ST) begin
            r.store_valid = 1'b1;
            sval = acc_q;
        end else if (ins.cmd == CMD_LDN) begin
            // Load negated only loads; it must not fall through into a store.
            acc_q = ~ins.operand;
        end else if (ins.cmd == CMD_STN) begin
            r.store_valid = 1'b1;
            sval = ~acc_q;
        end else if (ins.cmd == CMD_S || ins.cmd == CMD_R) begin
            if (acc_q == t_word'(1)) begin
                r.store_valid = 1'b1;
                sval = (ins.cmd == CMD_S) ? t_word'(1) : '0;
            end
        end else if (ins.cmd == CMD_END) begin
            r.scan_end = 1'b1;
            acc_q = '0;
            stk_level = 0;
        end else if (ins.cmd < CMD_END) begin
            // CAL, RET and JMP do nothing.
        end else if (ins.cmd <= CMD_LT) begin
            if (ins.modifier == MOD_PUSH) begin
                if (stk_level >= STACK_DEPTH) begin
                    fault = FAULT_OVER;
                end else begin
                    value_stk[stk_level] = acc_q;
                    oper_stk[stk_level] = ins.cmd;
                    stk_level++;
                    if (stk_level > max_level) max_level = stk_level;
                    acc_q = ins.operand;
                end
            end else begin
                b = (ins.modifier == MOD_NEG) ? ~ins.operand : ins.operand;
                acc_q = alu_op(ins.cmd, acc_q, b, fault);
            end
        end else if (ins.cmd == CMD_POP) begin
            if (stk_level == 0) begin
                fault = FAULT_UNDER;
            end else begin
                stk_level--;
                acc_q = alu_op(oper_stk[stk_level], value_stk[stk_level], acc_q, fault);
            end
        end else begin
            fault = FAULT_ILLEGAL;
        end
        r.acc = acc_q;
        if (r.store_valid) begin
            r.store_area  = ins.area;
            r.store_byte  = ins.byte_index;
            r.store_bit   = ins.bit_index;
            r.store_value = sval;
        end
        r.fault = fault;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Operand words biased toward the corners of the 16-bit range.
    function automatic t_word rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return t_word'(1);
            2: return '1;
            3: return t_word'($urandom_range(15));
            4: return t_word'(1) << (WORD_BITS - 1);
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] rand_alu();
        return 5'($urandom_range(CMD_LT, CMD_AND));
    endfunction

    // Modifier for an ALU op that is not a push; the reserved code acts as none.
    function automatic logic [1:0] rand_plain_mod();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6) return MOD_NONE;
        if (r < 9) return MOD_NEG;
        return MOD_RSVD;
    endfunction

    task automatic add_instr(logic [4:0] cmd, logic [1:0] modifier, t_word opv);
        t_instr ins;
        ins.cmd        = cmd;
        ins.modifier   = modifier;
        ins.operand    = opv;
        ins.area       = 8'($urandom_range(255));
        ins.byte_index = 8'($urandom_range(255));
        ins.bit_index  = 3'($urandom_range(7));
        ins.hold       = hold_req;
        hold_req = 1'b0;
        program_queue.push_back(ins);
        if (cmd >= CMD_AND && cmd <= CMD_LT && modifier == MOD_PUSH) begin
            if (gen_level < STACK_DEPTH) gen_level++;
        end else if (cmd == CMD_POP) begin
            if (gen_level > 0) gen_level--;
        end else if (cmd == CMD_END) begin
            gen_level = 0;
        end
        // CAL, RET, JMP and the illegal codes leave the unit untouched.
        if (!((cmd >= CMD_CAL && cmd <= CMD_JMP) || cmd > CMD_POP)) gen_effective++;
    endtask

    // A well-formed rung: a load, a mix of operators with nested parentheses,
    // optional closing pops and a store-type instruction, sometimes an END.
    task automatic gen_expression();
        int unsigned n;
        int unsigned r;
        n = $urandom_range(8, 1);
        if ($urandom_range(1)) add_instr(CMD_LD, 2'($urandom_range(3)), rand_word());
        else add_instr(CMD_LDN, 2'($urandom_range(3)), rand_word());
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 25 && gen_level < STACK_DEPTH)
                add_instr(rand_alu(), MOD_PUSH, rand_word());
            else if (r < 45 && gen_level > 0)
                add_instr(CMD_POP, 2'($urandom_range(3)), rand_word());
            else
                add_instr(rand_alu(), rand_plain_mod(), rand_word());
        end
        while (gen_level > 0 && $urandom_range(3) != 0)
            add_instr(CMD_POP, MOD_NONE, rand_word());
        case ($urandom_range(4))
            0: add_instr(CMD_ST, 2'($urandom_range(3)), rand_word());
            1: add_instr(CMD_STN, 2'($urandom_range(3)), rand_word());
            default: begin
                // A compare leaves 0 or 1, so set and reset fire about half the time.
                add_instr(5'($urandom_range(CMD_LT, CMD_GT)), rand_plain_mod(),
                          t_word'($urandom_range(3)));
                add_instr($urandom_range(1) ? CMD_S : CMD_R, 2'($urandom_range(3)),
                          rand_word());
            end
        endcase
        if ($urandom_range(4) == 0) add_instr(CMD_END, 2'($urandom_range(3)), rand_word());
    endtask

    // Nest one level past the stack depth, then unwind one past empty.
    task automatic gen_deep_nest();
        add_instr(CMD_LD, MOD_NONE, rand_word());
        repeat (STACK_DEPTH + 1) add_instr(rand_alu(), MOD_PUSH, rand_word());
        repeat (STACK_DEPTH + 1) add_instr(CMD_POP, MOD_NONE, rand_word());
        add_instr(CMD_END, MOD_NONE, rand_word());
    endtask

    // Driver. An item leaves the input port when it is accepted; a new one is
    // put up only when the port is empty or was just emptied, so a stalled
    // item never changes. Each driven signal gets one assignment per edge.
    always @(posedge i_clk) begin : driver
        logic   accepted;
        logic   offer;
        t_instr next_ins;
        int unsigned idle_pct;
        accepted = i_rst_n && i_valid && !o_stall;
        if (accepted) begin
            exec_results.push_back(execute_instr({i_cmd, i_modifier, i_operand_value,
                                                  i_area, i_byte_index, i_bit_index,
                                                  1'b0}));
            issued_count++;
        end
        idle_pct = (phase == 2'd0) ? 20 : (phase == 2'd1) ? 55 : 0;
        offer = 1'b0;
        if (i_rst_n && (!i_valid || accepted) && program_queue.size() != 0) begin
            // A held item waits until the unit has returned every result.
            if ((!program_queue[0].hold || issued_count == retired_count) &&
                    $urandom_range(99) >= idle_pct) begin
                offer = 1'b1;
            end
        end
        if (offer) begin
            next_ins = program_queue.pop_front();
            i_cmd           <= next_ins.cmd;
            i_modifier      <= next_ins.modifier;
            i_operand_value <= next_ins.operand;
            i_area          <= next_ins.area;
            i_byte_index    <= next_ins.byte_index;
            i_bit_index     <= next_ins.bit_index;
        end
        if (offer) begin
            i_valid <= 1'b1;
        end else if (!i_valid || accepted) begin
            i_valid <= 1'b0;
        end
        phase <= (issued_count < PHASE_LEN) ? 2'd0 :
                 (issued_count < 2 * PHASE_LEN) ? 2'd1 : 2'd2;
    end

    // Monitor. Every accepted result item is compared with the oldest
    // prediction, and the stall toward the unit is redrawn each cycle.
    always @(posedge i_clk) begin : monitor
        t_result want;
        int unsigned stall_pct;
        if (i_rst_n && o_valid && !i_stall) begin
            retired_count <= retired_count + 1;
            if (exec_results.size() == 0) begin
                $error("result item with no instruction outstanding: acc 'h%0h fault %0d",
                       o_accumulator, o_fault);
                error_count++;
            end else begin
                want = exec_results.pop_front();
                check_field("accumulator", want.acc, o_accumulator);
                check_field("store_valid", want.store_valid, o_store_valid);
                check_field("store_area", want.store_area, o_store_area);
                check_field("store_byte", want.store_byte, o_store_byte);
                check_field("store_bit", want.store_bit, o_store_bit);
                check_field("store_value", want.store_value, o_store_value);
                check_field("scan_end", want.scan_end, o_scan_end);
                check_field("fault", want.fault, o_fault);
                if (want.store_valid) store_tally++;
                if (want.scan_end) end_tally++;
                fault_tally[want.fault]++;
            end
        end
        stall_pct = (phase == 2'd0) ? 55 : (phase == 2'd1) ? 20 : 0;
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    initial begin : stimulus
        int unsigned eff_base;
        int unsigned next_hold_at;
        int unsigned r;
        for (int i = 0; i < 8; i++) fault_tally[i] = 0;

        // Directed part: every opcode, the negated forms, set and reset with
        // and without an accumulator of one, wrap, divide by zero, a push and
        // pop pair, pop on an empty stack, illegal codes and end of scan.
        add_instr(CMD_LDN, MOD_NONE, '1);
        add_instr(CMD_STN, MOD_NONE, '0);
        add_instr(CMD_OR, MOD_NONE, t_word'(1));
        add_instr(CMD_S, MOD_NEG, '0);
        add_instr(CMD_R, MOD_PUSH, '0);
        add_instr(CMD_ST, MOD_NONE, '1);
        add_instr(CMD_AND, MOD_RSVD, '1);
        add_instr(CMD_XOR, MOD_NEG, 16'h00ff);
        add_instr(CMD_ANDN, MOD_NONE, 16'h0f0f);
        add_instr(CMD_ORN, MOD_NONE, 16'h8000);
        add_instr(CMD_XORN, MOD_NONE, 16'h1234);
        add_instr(CMD_ADD, MOD_NONE, '1);
        add_instr(CMD_SUB, MOD_NEG, '0);
        add_instr(CMD_MUL, MOD_NONE, '1);
        add_instr(CMD_DIV, MOD_NEG, '1);
        add_instr(CMD_DIV, MOD_NONE, t_word'(3));
        add_instr(CMD_GT, MOD_NONE, '0);
        add_instr(CMD_GE, MOD_PUSH, '1);
        add_instr(CMD_EQ, MOD_NONE, '1);
        add_instr(CMD_NE, MOD_NONE, '0);
        add_instr(CMD_LE, MOD_NONE, '0);
        add_instr(CMD_LT, MOD_NONE, t_word'(1));
        add_instr(CMD_POP, MOD_NEG, '1);
        add_instr(CMD_POP, MOD_NONE, '0);
        add_instr(CMD_CAL, MOD_PUSH, '1);
        add_instr(CMD_RET, MOD_NEG, '0);
        add_instr(CMD_JMP, MOD_RSVD, '1);
        add_instr(CMD_POP + 5'd1, MOD_NONE, '1);
        add_instr(5'd31, MOD_RSVD, '1);
        add_instr(CMD_LD, MOD_NONE, t_word'(2));
        add_instr(CMD_S, MOD_NONE, '1);
        add_instr(CMD_END, MOD_NONE, '0);

        // Random part, mostly well-formed rungs. The first random item and the
        // first item of each later traffic phase wait for the unit to drain.
        eff_base = gen_effective;
        hold_req = 1'b1;
        gen_deep_nest();
        next_hold_at = PHASE_LEN;
        while (gen_effective - eff_base < RANDOM_ITEMS) begin
            if (program_queue.size() >= next_hold_at) begin
                hold_req = 1'b1;
                next_hold_at += PHASE_LEN;
            end
            r = $urandom_range(99);
            if (r < 75) begin
                gen_expression();
            end else if (r < 82) begin
                gen_deep_nest();
            end else begin
                add_instr(5'($urandom_range(31)), 2'($urandom_range(3)), rand_word());
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (program_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (retired_count != issued_count) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (exec_results.size() != 0) begin
            $error("%0d predicted results never arrived", exec_results.size());
            error_count++;
        end

        $display("Executed %0d instructions: %0d stores, %0d scan ends, stack depth up to %0d.",
                 issued_count, store_tally, end_tally, max_level);
        $display("Faults seen: illegal %0d, overflow %0d, underflow %0d, divide by zero %0d.",
                 fault_tally[FAULT_ILLEGAL], fault_tally[FAULT_OVER],
                 fault_tally[FAULT_UNDER], fault_tally[FAULT_DIVZERO]);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial begin : watchdog
        #TIMEOUT;
        $display("simulation failed");
        $finish;
    end

endmodule
